// ===== rtl/multi_voice_sample_mixer_assert.svh =====
// assertion macros used by the checker file
`ifndef MULTI_VOICE_SAMPLE_MIXER_ASSERT_SVH
`define MULTI_VOICE_SAMPLE_MIXER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define MVSM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mvsm check failed");

// next-cycle implication, disabled in reset
`define MVSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mvsm check failed");

`endif

// ===== rtl/mvsm_pkg.sv =====
// ----------------------------------------------------------------------------
// mvsm_pkg
// Types and fixed constants of the multi-voice sample mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package mvsm_pkg;

  localparam int SAMPLE_WORDS = 65536;
  localparam int ADDR_W       = 16;
  localparam int FRAC_BITS    = 14;
  localparam int ROUND_BIAS   = 8192;
  localparam int MIX_W        = 24;

  localparam logic [15:0]              UNITY_GAIN = 16'd16384;
  localparam logic signed [MIX_W-1:0]  MIX_MAX    = 24'sh7FFFFF;
  localparam logic signed [MIX_W-1:0]  MIX_MIN    = 24'sh800000;

  typedef enum logic [2:0] {
    MODE_TICK    = 3'd0,
    MODE_WRITE   = 3'd1,
    MODE_DEFINE  = 3'd2,
    MODE_VOLUME  = 3'd3,
    MODE_PLAY    = 3'd4,
    MODE_STOP    = 3'd5,
    MODE_SEEK    = 3'd6,
    MODE_RELEASE = 3'd7
  } mvsm_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VOICE,
    ST_ISSUE,
    ST_DRAIN,
    ST_OUT
  } mvsm_state_t;

  // one sample read handed to the multiply-accumulate pipe
  typedef struct packed {
    logic        valid;
    logic [2:0]  ch;
    logic [15:0] gain;
  } mvsm_issue_t;

endpackage

`default_nettype wire

// ===== rtl/mvsm_sample_mem.sv =====
// ----------------------------------------------------------------------------
// mvsm_sample_mem
// Shared sample memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mvsm_sample_mem (
  input  wire logic                               clk,
  input  wire logic                               we,
  input  wire logic [mvsm_pkg::ADDR_W-1:0]        waddr,
  input  wire logic [15:0]                        wdata,
  input  wire logic [mvsm_pkg::ADDR_W-1:0]        raddr,
  output logic signed [15:0]                      rdata
);

  logic [15:0] mem [mvsm_pkg::SAMPLE_WORDS];
  logic [15:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = $signed(rdata_r);

endmodule

`default_nettype wire

// ===== rtl/mvsm_mac.sv =====
// ----------------------------------------------------------------------------
// mvsm_mac
// Shared gain multiplier, rounding and per-channel accumulators.
// ----------------------------------------------------------------------------
`default_nettype none

module mvsm_mac #(
  parameter int CHANNELS = 2,
  parameter int ACC_W    = 24
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           clear,
  input  wire mvsm_pkg::mvsm_issue_t          issue,
  input  wire logic signed [15:0]             rdata,
  input  wire logic [2:0]                     sel_ch,
  output logic                                busy,
  output logic signed [mvsm_pkg::MIX_W-1:0]   mix_sat
);

  localparam int CW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW   = 33;
  localparam int TW   = PW - mvsm_pkg::FRAC_BITS;
  localparam int SATW = (ACC_W > mvsm_pkg::MIX_W) ? ACC_W : mvsm_pkg::MIX_W;

  logic                    va_r, vb_r;
  logic [CW-1:0]           cha_r, chb_r;
  logic [15:0]             gaina_r;
  logic signed [PW-1:0]    prod_r;
  logic signed [ACC_W-1:0] acc_r [CHANNELS];
  logic signed [PW-1:0]    rnd;
  logic signed [TW-1:0]    term;
  logic signed [SATW-1:0]  ext;

  // pipe valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= issue.valid;
      vb_r <= va_r;
    end
  end

  // align with memory read, then multiply
  always_ff @(posedge clk) begin
    cha_r   <= issue.ch[CW-1:0];
    gaina_r <= issue.gain;
    chb_r   <= cha_r;
    prod_r  <= PW'(rdata) * PW'($signed({1'b0, gaina_r}));
  end

  // round half up to q1.15
  assign rnd  = prod_r + PW'(mvsm_pkg::ROUND_BIAS);
  assign term = $signed(rnd[PW-1:mvsm_pkg::FRAC_BITS]);

  // accumulate
  always_ff @(posedge clk) begin
    if (clear) begin
      for (int i = 0; i < CHANNELS; i++) begin
        acc_r[i] <= '0;
      end
    end else if (vb_r) begin
      acc_r[chb_r] <= acc_r[chb_r] + ACC_W'(term);
    end
  end

  assign busy = va_r | vb_r;

  // saturate selected channel to 24 bits
  always_comb begin
    ext = SATW'(acc_r[sel_ch[CW-1:0]]);
    priority if (ext > SATW'(mvsm_pkg::MIX_MAX)) begin
      mix_sat = mvsm_pkg::MIX_MAX;
    end else if (ext < SATW'(mvsm_pkg::MIX_MIN)) begin
      mix_sat = mvsm_pkg::MIX_MIN;
    end else begin
      mix_sat = ext[mvsm_pkg::MIX_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/multi_voice_sample_mixer.sv =====
// ----------------------------------------------------------------------------
// multi_voice_sample_mixer
// Sample-playback mixer: voice table, sequencer and shared mix datapath.
// ----------------------------------------------------------------------------
// Input channel (in_*): one command request per accept. Mode selects tick,
// sample write or a voice command. Non-tick commands complete at the accept
// edge and in_ready stays high.
// A tick request mixes one frame: the sequencer visits every voice in ST_VOICE
// and, for a playing voice, issues one sample memory read per channel through
// the single read port in ST_ISSUE, then waits in ST_DRAIN until the multiply
// pipe is empty, then offers one result per channel in ST_OUT.
// in_ready is low from a tick until its last result is taken.
// Result channel (out_*): CHANNELS requests per tick, channel 0 first, with
// out_last on the final one. Stalls hold the result and the block.
// Reset clears the voice table (gain to unity); sample memory is undefined
// until written.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_voice_sample_mixer #(
  parameter int VOICES   = 16,
  parameter int CHANNELS = 2
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_mode,
  input  wire logic [3:0]         in_voice,
  input  wire logic [15:0]        in_address,
  input  wire logic [15:0]        in_length_frames,
  input  wire logic [15:0]        in_frame_index,
  input  wire logic signed [15:0] in_sample_value,
  input  wire logic [15:0]        in_volume,
  input  wire logic               in_loop_enable,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [23:0]      out_mixed_sample,
  output logic [2:0]              out_channel,
  output logic                    out_last
);

  localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ACC_W = 20 + $clog2(VOICES);

  mvsm_pkg::mvsm_state_t state_r, state_nxt;
  logic [VW-1:0]  vidx_r, vidx_nxt;
  logic [CW-1:0]  ch_r, ch_nxt;
  logic [15:0]    base_r, base_nxt;
  logic [15:0]    gain_q_r, gain_q_nxt;

  // voice table
  logic [15:0] start_r [VOICES];
  logic [15:0] len_r   [VOICES];
  logic [15:0] cur_r   [VOICES];
  logic [15:0] gain_r  [VOICES];
  logic        loop_r  [VOICES];
  logic        play_r  [VOICES];
  logic        use_r   [VOICES];

  mvsm_pkg::mvsm_mode_t  mode;
  mvsm_pkg::mvsm_issue_t issue;
  logic          accept, cmd_ok, tick_go, mac_busy;
  logic [VW-1:0] cidx;
  logic          active, at_end, wrap_pre, go, stop_pre, fin, last_voice, last_ch;
  logic [15:0]   eff_cur, inc;
  logic [15:0]   raddr;
  logic signed [15:0] rdata;

  assign mode    = mvsm_pkg::mvsm_mode_t'(in_mode);
  assign accept  = in_valid && in_ready;
  assign tick_go = accept && (mode == mvsm_pkg::MODE_TICK);
  assign cidx    = VW'(in_voice);
  assign cmd_ok  = accept && (int'(in_voice) < VOICES);

  // current voice evaluation
  always_comb begin
    active   = use_r[vidx_r] && play_r[vidx_r];
    at_end   = cur_r[vidx_r] >= len_r[vidx_r];
    wrap_pre = at_end && loop_r[vidx_r] && (len_r[vidx_r] != 16'd0);
    go       = active && (!at_end || wrap_pre);
    stop_pre = active && at_end && !loop_r[vidx_r];
    eff_cur  = wrap_pre ? 16'd0 : cur_r[vidx_r];
    inc      = eff_cur + 16'd1;
    fin      = inc >= len_r[vidx_r];
  end

  assign last_voice = (vidx_r == VW'(VOICES - 1));
  assign last_ch    = (ch_r == CW'(CHANNELS - 1));

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mvsm_pkg::ST_IDLE;
      vidx_r  <= '0;
      ch_r    <= '0;
    end else begin
      state_r <= state_nxt;
      vidx_r  <= vidx_nxt;
      ch_r    <= ch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r   <= base_nxt;
    gain_q_r <= gain_q_nxt;
  end

  // next state and outputs
  always_comb begin
    state_nxt  = state_r;
    vidx_nxt   = vidx_r;
    ch_nxt     = ch_r;
    base_nxt   = base_r;
    gain_q_nxt = gain_q_r;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    issue      = '0;
    unique case (state_r)
      mvsm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (tick_go) begin
          vidx_nxt  = '0;
          state_nxt = mvsm_pkg::ST_VOICE;
        end
      end
      mvsm_pkg::ST_VOICE: begin
        if (go) begin
          base_nxt   = start_r[vidx_r] + 16'(eff_cur * 16'(CHANNELS));
          gain_q_nxt = gain_r[vidx_r];
          ch_nxt     = '0;
          state_nxt  = mvsm_pkg::ST_ISSUE;
        end else if (last_voice) begin
          state_nxt = mvsm_pkg::ST_DRAIN;
        end else begin
          vidx_nxt = vidx_r + VW'(1);
        end
      end
      mvsm_pkg::ST_ISSUE: begin
        issue.valid = 1'b1;
        issue.ch    = 3'(ch_r);
        issue.gain  = gain_q_r;
        if (!last_ch) begin
          ch_nxt = ch_r + CW'(1);
        end else if (last_voice) begin
          state_nxt = mvsm_pkg::ST_DRAIN;
        end else begin
          vidx_nxt  = vidx_r + VW'(1);
          state_nxt = mvsm_pkg::ST_VOICE;
        end
      end
      mvsm_pkg::ST_DRAIN: begin
        if (!mac_busy) begin
          ch_nxt    = '0;
          state_nxt = mvsm_pkg::ST_OUT;
        end
      end
      mvsm_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (last_ch) begin
            state_nxt = mvsm_pkg::ST_IDLE;
          end else begin
            ch_nxt = ch_r + CW'(1);
          end
        end
      end
      default: state_nxt = mvsm_pkg::ST_IDLE;
    endcase
  end

  // voice table updates: commands in idle, cursor steps during a tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VOICES; i++) begin
        start_r[i] <= '0;
        len_r[i]   <= '0;
        cur_r[i]   <= '0;
        gain_r[i]  <= mvsm_pkg::UNITY_GAIN;
        loop_r[i]  <= 1'b0;
        play_r[i]  <= 1'b0;
        use_r[i]   <= 1'b0;
      end
    end else if (state_r == mvsm_pkg::ST_VOICE) begin
      if (go) begin
        if (fin) begin
          cur_r[vidx_r] <= loop_r[vidx_r] ? 16'd0 : inc;
          if (!loop_r[vidx_r]) begin
            play_r[vidx_r] <= 1'b0;
          end
        end else begin
          cur_r[vidx_r] <= inc;
        end
      end else if (stop_pre) begin
        play_r[vidx_r] <= 1'b0;
      end
    end else if (cmd_ok) begin
      unique case (mode)
        mvsm_pkg::MODE_DEFINE: begin
          start_r[cidx] <= in_address;
          len_r[cidx]   <= in_length_frames;
          cur_r[cidx]   <= '0;
          gain_r[cidx]  <= mvsm_pkg::UNITY_GAIN;
          loop_r[cidx]  <= in_loop_enable;
          play_r[cidx]  <= 1'b0;
          use_r[cidx]   <= 1'b1;
        end
        mvsm_pkg::MODE_VOLUME: begin
          if (use_r[cidx]) gain_r[cidx] <= in_volume;
        end
        mvsm_pkg::MODE_PLAY: begin
          if (use_r[cidx]) begin
            cur_r[cidx]  <= '0;
            loop_r[cidx] <= in_loop_enable;
            play_r[cidx] <= 1'b1;
          end
        end
        mvsm_pkg::MODE_STOP: begin
          if (use_r[cidx]) play_r[cidx] <= 1'b0;
        end
        mvsm_pkg::MODE_SEEK: begin
          if (use_r[cidx]) begin
            cur_r[cidx] <= (in_frame_index < len_r[cidx]) ? in_frame_index : 16'd0;
          end
        end
        mvsm_pkg::MODE_RELEASE: begin
          if (use_r[cidx]) begin
            use_r[cidx]  <= 1'b0;
            play_r[cidx] <= 1'b0;
          end
        end
        mvsm_pkg::MODE_TICK, mvsm_pkg::MODE_WRITE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // sample memory read address for the channel being issued
  assign raddr = base_r + 16'(ch_r);

  mvsm_sample_mem u_mem (
    .clk   (clk),
    .we    (accept && (mode == mvsm_pkg::MODE_WRITE)),
    .waddr (in_address),
    .wdata (in_sample_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  mvsm_mac #(
    .CHANNELS (CHANNELS),
    .ACC_W    (ACC_W)
  ) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (tick_go),
    .issue   (issue),
    .rdata   (rdata),
    .sel_ch  (3'(ch_r)),
    .busy    (mac_busy),
    .mix_sat (out_mixed_sample)
  );

  assign out_channel = 3'(ch_r);
  assign out_last    = last_ch;

endmodule

`default_nettype wire

// ===== rtl/mvsm_checker.sv =====
// ----------------------------------------------------------------------------
// mvsm_checker
// Port-level checks of the mixer's handshake and frame sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_voice_sample_mixer_assert.svh"

module mvsm_checker #(
  parameter int CHANNELS = 2
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [23:0] out_mixed_sample,
  input wire logic [2:0]  out_channel,
  input wire logic        out_last
);

  // a stalled result holds
  `MVSM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_mixed_sample) && $stable(out_channel))

  // no new request while a frame is being delivered
  `MVSM_ASSERT_NOW(a_busy_out, clk, rst_n, out_valid, !in_ready)

  // frame continues until its last channel
  `MVSM_ASSERT_NEXT(a_frame_cont, clk, rst_n, out_valid && out_ready && !out_last, out_valid && (out_channel == $past(out_channel) + 3'd1))

  // after the last channel the block takes requests again
  `MVSM_ASSERT_NEXT(a_frame_end, clk, rst_n, out_valid && out_ready && out_last, in_ready && !out_valid)

  // last flags the final channel
  `MVSM_ASSERT_NOW(a_last_ch, clk, rst_n, out_valid, out_last == (out_channel == 3'(CHANNELS - 1)))

endmodule

bind multi_voice_sample_mixer mvsm_checker #(.CHANNELS(CHANNELS)) u_mvsm_checker (.*);

`default_nettype wire

// ===== bench/tb_multi_voice_sample_mixer.sv =====
// ----------------------------------------------------------------------------
// tb_multi_voice_sample_mixer
// Self-checking bench for the sample mixer: a scoreboard keeps its own copy of
// the voice table and the written sample words, predicts the mixed frame of
// every tick and checks each result request; directed commands come first,
// then random voice sequences under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_multi_voice_sample_mixer;

  localparam int NUM_VOICES = 16;
  localparam int NUM_CH     = 2;
  localparam int RAND_ITEMS = 330;
  localparam int CYCLE_CAP  = 600000;

  typedef struct {
    mvsm_pkg::mvsm_mode_t mode;
    logic [3:0]  voice;
    logic [15:0] address;
    logic [15:0] length_frames;
    logic [15:0] frame_index;
    logic [15:0] sample_value;
    logic [15:0] volume;
    logic        loop_enable;
  } mix_cmd_t;

  typedef struct {
    logic signed [23:0] mix;
    logic [2:0]         ch;
    logic               last;
  } mix_out_t;

  // predicted voice table, written sample words and pending frame results
  class mix_scoreboard;
    logic [15:0] mem [int];
    logic [15:0] start_w [NUM_VOICES];
    logic [15:0] len_f [NUM_VOICES];
    logic [15:0] cur_f [NUM_VOICES];
    logic [15:0] gain [NUM_VOICES];
    bit          looping [NUM_VOICES];
    bit          playing [NUM_VOICES];
    bit          in_use [NUM_VOICES];
    mix_out_t    pending [$];
    int          errors;

    function void clear_table();
      for (int v = 0; v < NUM_VOICES; v++) begin
        start_w[v] = '0; len_f[v] = '0; cur_f[v] = '0;
        gain[v] = mvsm_pkg::UNITY_GAIN;
        looping[v] = 0; playing[v] = 0; in_use[v] = 0;
      end
    endfunction

    // sample words the next tick reads that were never written
    function void unwritten_reads(ref int words[$]);
      logic [15:0] c;
      int idx;
      for (int v = 0; v < NUM_VOICES; v++) begin
        if (!in_use[v] || !playing[v]) continue;
        c = cur_f[v];
        if (c >= len_f[v]) begin
          if (looping[v] && len_f[v] != 0) c = '0;
          else continue;
        end
        for (int ch = 0; ch < NUM_CH; ch++) begin
          idx = (int'(start_w[v]) + int'(c) * NUM_CH + ch) & 16'hFFFF;
          if (!mem.exists(idx)) words.push_back(idx);
        end
      end
    endfunction

    // apply one accepted command request
    function void note(mix_cmd_t c);
      longint acc [NUM_CH];
      longint s, p;
      int idx, v;
      mix_out_t r;
      v = int'(c.voice);
      case (c.mode)
        mvsm_pkg::MODE_TICK: begin
          foreach (acc[i]) acc[i] = 0;
          for (int k = 0; k < NUM_VOICES; k++) begin
            if (!in_use[k] || !playing[k]) continue;
            if (cur_f[k] >= len_f[k]) begin
              if (looping[k] && len_f[k] != 0) cur_f[k] = '0;
              else begin
                if (!looping[k]) playing[k] = 0;
                continue;
              end
            end
            for (int ch = 0; ch < NUM_CH; ch++) begin
              idx = (int'(start_w[k]) + int'(cur_f[k]) * NUM_CH + ch) & 16'hFFFF;
              s = longint'($signed(mem[idx]));
              p = s * longint'({1'b0, gain[k]}) + 8192;
              acc[ch] += (p >>> 14);
            end
            cur_f[k] = cur_f[k] + 16'd1;
            if (cur_f[k] >= len_f[k]) begin
              if (looping[k]) cur_f[k] = '0;
              else playing[k] = 0;
            end
          end
          for (int ch = 0; ch < NUM_CH; ch++) begin
            if (acc[ch] > 8388607) acc[ch] = 8388607;
            if (acc[ch] < -8388608) acc[ch] = -8388608;
            r.mix  = acc[ch][23:0];
            r.ch   = ch[2:0];
            r.last = (ch == NUM_CH - 1);
            pending.push_back(r);
          end
        end
        mvsm_pkg::MODE_WRITE: mem[int'(c.address)] = c.sample_value;
        mvsm_pkg::MODE_DEFINE: begin
          start_w[v] = c.address; len_f[v] = c.length_frames; cur_f[v] = '0;
          gain[v] = mvsm_pkg::UNITY_GAIN; looping[v] = c.loop_enable;
          playing[v] = 0; in_use[v] = 1;
        end
        default: begin
          if (in_use[v]) begin
            case (c.mode)
              mvsm_pkg::MODE_VOLUME: gain[v] = c.volume;
              mvsm_pkg::MODE_PLAY: begin
                cur_f[v] = '0; looping[v] = c.loop_enable; playing[v] = 1;
              end
              mvsm_pkg::MODE_STOP: playing[v] = 0;
              mvsm_pkg::MODE_SEEK:
                cur_f[v] = (c.frame_index < len_f[v]) ? c.frame_index : '0;
              default: begin
                in_use[v] = 0; playing[v] = 0;
              end
            endcase
          end
        end
      endcase
    endfunction

    // compare one result request with the oldest prediction
    function void check(mix_out_t a);
      mix_out_t e;
      if (pending.size() == 0) begin
        $error("unexpected result: mixed_sample %0d channel %0d", a.mix, a.ch);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.mix !== e.mix) begin
        $error("mixed_sample: expected %0d, got %0d", e.mix, a.mix);
        errors++;
      end
      if (a.ch !== e.ch) begin
        $error("channel: expected %0d, got %0d", e.ch, a.ch);
        errors++;
      end
      if (a.last !== e.last) begin
        $error("last: expected %0d, got %0d", e.last, a.last);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_ready;
  logic [2:0]         in_mode = '0;
  logic [3:0]         in_voice = '0;
  logic [15:0]        in_address = '0;
  logic [15:0]        in_length_frames = '0;
  logic [15:0]        in_frame_index = '0;
  logic signed [15:0] in_sample_value = '0;
  logic [15:0]        in_volume = '0;
  logic               in_loop_enable = 0;
  logic               out_valid;
  logic               out_ready = 0;
  logic signed [23:0] out_mixed_sample;
  logic [2:0]         out_channel;
  logic               out_last;

  mix_scoreboard sb = new();
  int  cycles = 0;
  int  burst_left = 0;
  int  sent = 0;
  bit  hold_sink = 0;

  multi_voice_sample_mixer DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_mode(in_mode), .in_voice(in_voice), .in_address(in_address),
    .in_length_frames(in_length_frames), .in_frame_index(in_frame_index),
    .in_sample_value(in_sample_value), .in_volume(in_volume),
    .in_loop_enable(in_loop_enable),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_mixed_sample(out_mixed_sample), .out_channel(out_channel),
    .out_last(out_last)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check('{mix: out_mixed_sample, ch: out_channel, last: out_last});
  end

  // sink stall pattern, with one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_sink) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_sink = 0;
      end
      case ((cycles / 300) % 3)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  function automatic mix_cmd_t mk(mvsm_pkg::mvsm_mode_t m, int v, int a, int l,
                                  int f, int s, int vol, int lp);
    mix_cmd_t c;
    c.mode = m; c.voice = 4'(v); c.address = 16'(a); c.length_frames = 16'(l);
    c.frame_index = 16'(f); c.sample_value = 16'(s); c.volume = 16'(vol);
    c.loop_enable = lp[0];
    return c;
  endfunction

  // offer one request and wait for its accept, then maybe leave a gap
  task automatic send(mix_cmd_t c);
    in_valid <= 1'b1;
    in_mode <= c.mode; in_voice <= c.voice; in_address <= c.address;
    in_length_frames <= c.length_frames; in_frame_index <= c.frame_index;
    in_sample_value <= c.sample_value; in_volume <= c.volume;
    in_loop_enable <= c.loop_enable;
    do @(posedge clk); while (!in_ready);
    sb.note(c);
    sent++;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 20);
    end else begin
      burst_left--;
    end
  endtask

  // fill any sample words the tick would read, then tick
  task automatic tick();
    int words [$];
    sb.unwritten_reads(words);
    foreach (words[i])
      send(mk(mvsm_pkg::MODE_WRITE, $urandom, words[i], $urandom, $urandom,
              $urandom, $urandom, $urandom));
    send(mk(mvsm_pkg::MODE_TICK, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom));
  endtask

  // sender pauses until every expected result has come
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // random voice command or tick, with a mostly live voice
  task automatic random_cmd();
    mix_cmd_t c;
    int r;
    c = mk(mvsm_pkg::MODE_WRITE, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom);
    if ($urandom_range(0, 3) != 0) c.voice = 4'($urandom_range(0, 5));
    if ($urandom_range(0, 1) != 0) c.length_frames = 16'($urandom_range(0, 8));
    if ($urandom_range(0, 1) != 0) c.frame_index = 16'($urandom_range(0, 9));
    r = $urandom_range(0, 99);
    if (r < 35) begin
      tick();
      return;
    end
    else if (r < 45) c.mode = mvsm_pkg::MODE_WRITE;
    else if (r < 57) c.mode = mvsm_pkg::MODE_DEFINE;
    else if (r < 67) c.mode = mvsm_pkg::MODE_VOLUME;
    else if (r < 79) c.mode = mvsm_pkg::MODE_PLAY;
    else if (r < 85) c.mode = mvsm_pkg::MODE_STOP;
    else if (r < 94) c.mode = mvsm_pkg::MODE_SEEK;
    else c.mode = mvsm_pkg::MODE_RELEASE;
    send(c);
  endtask

  initial begin
    bit mid_done;
    mid_done = 0;
    sb.clear_table();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, wrap of memory, gains, zero length, ignored commands
    send(mk(mvsm_pkg::MODE_WRITE, 0, 65534, 0, 0, 16'h8000, 0, 0));
    send(mk(mvsm_pkg::MODE_WRITE, 15, 65535, 65535, 65535, 16'h7FFF, 65535, 1));
    send(mk(mvsm_pkg::MODE_WRITE, 0, 0, 0, 0, 16'h0001, 0, 0));
    send(mk(mvsm_pkg::MODE_WRITE, 0, 1, 0, 0, 16'hFFFF, 0, 0));
    send(mk(mvsm_pkg::MODE_PLAY, 14, 0, 0, 0, 0, 0, 1));
    send(mk(mvsm_pkg::MODE_DEFINE, 0, 65534, 2, 0, 0, 0, 1));
    send(mk(mvsm_pkg::MODE_PLAY, 0, 0, 0, 0, 0, 0, 1));
    tick(); tick(); tick();
    send(mk(mvsm_pkg::MODE_VOLUME, 0, 0, 0, 0, 0, 65535, 0));
    tick();
    send(mk(mvsm_pkg::MODE_VOLUME, 0, 0, 0, 0, 0, 0, 0));
    tick();
    send(mk(mvsm_pkg::MODE_DEFINE, 15, 100, 0, 0, 0, 0, 1));
    send(mk(mvsm_pkg::MODE_PLAY, 15, 0, 0, 0, 0, 0, 1));
    send(mk(mvsm_pkg::MODE_DEFINE, 14, 200, 0, 0, 0, 0, 0));
    send(mk(mvsm_pkg::MODE_PLAY, 14, 0, 0, 0, 0, 0, 0));
    tick();
    send(mk(mvsm_pkg::MODE_SEEK, 0, 0, 0, 65535, 0, 0, 0));
    send(mk(mvsm_pkg::MODE_SEEK, 0, 0, 0, 1, 0, 0, 0));
    send(mk(mvsm_pkg::MODE_DEFINE, 1, 65535, 65535, 0, 0, 0, 0));
    send(mk(mvsm_pkg::MODE_PLAY, 1, 0, 0, 0, 0, 0, 0));
    tick();
    send(mk(mvsm_pkg::MODE_STOP, 0, 0, 0, 0, 0, 0, 0));
    send(mk(mvsm_pkg::MODE_RELEASE, 1, 0, 0, 0, 0, 0, 0));
    send(mk(mvsm_pkg::MODE_VOLUME, 1, 0, 0, 0, 0, 100, 0));
    tick();

    // sink holds off while ticks keep coming
    hold_sink = 1;
    repeat (10) tick();
    wait_drained();

    // random voice sequences with random content, plus loose commands
    while (sent < RAND_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        int v;
        v = $urandom_range(0, 15);
        send(mk(mvsm_pkg::MODE_DEFINE, v, $urandom,
                ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 6),
                0, 0, 0, $urandom));
        send(mk(mvsm_pkg::MODE_VOLUME, v, 0, 0, 0, 0, $urandom, 0));
        send(mk(mvsm_pkg::MODE_PLAY, v, 0, 0, 0, 0, 0, $urandom));
        repeat ($urandom_range(1, 5)) tick();
      end else begin
        random_cmd();
      end
      if (!mid_done && sent > RAND_ITEMS / 2) begin
        wait_drained();
        mid_done = 1;
      end
    end

    wait_drained();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
